FILE: hdl/ftrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftrc_pkg: shared types and constants of the five-tuple rule classifier
// Word formats on both channels, the stored rule layout and the control
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package ftrc_pkg;

    localparam int DEF_MAX_RULES = 64;
    localparam int DEF_RANK_BITS = 16;
    localparam int ID_W          = 6;
    localparam int RANK_W        = 16;

    localparam logic [3:0] IPV4_VERSION = 4'd4;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_MATCH = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic        action;
        logic [3:0]  ip_version;
        logic [7:0]  protocol;
        logic [15:0] l4_src;
        logic [15:0] l4_dst;
        logic [31:0] src_addr;
        logic [31:0] src_addr_mask;
        logic [31:0] dst_addr;
        logic [31:0] dst_addr_mask;
        logic [15:0] rule_rank;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   matched_id;
        logic [RANK_W-1:0] matched_rank;
    } t_out_word;

    // rule as held in the table, rank kept in a separate memory
    typedef struct packed {
        logic [3:0]  ip_version;
        logic [7:0]  protocol;
        logic [15:0] l4_src;
        logic [15:0] l4_dst;
        logic [31:0] src_addr;
        logic [31:0] src_addr_mask;
        logic [31:0] dst_addr;
        logic [31:0] dst_addr_mask;
    } t_rule_key;

    typedef struct packed {
        logic [3:0]  ip_version;
        logic [7:0]  protocol;
        logic [15:0] l4_src;
        logic [15:0] l4_dst;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } t_flow_key;

    typedef struct packed {
        logic capture;   // take the accepted word
        logic wr_en;     // store the accepted rule at the fill count
        logic rd_en;     // read the rule at the scan index, advance it
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic count_zero;
        logic last_rd;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: hdl/ftrc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftrc_ctrl: classifier sequencer
// Accepts a word, decides between add and table scan, steps the scan and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module ftrc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_action,
    input  ftrc_pkg::t_dp_sts i_sts,
    output logic            o_in_ready,
    output ftrc_pkg::t_dp_cmd o_cmd
);
    import ftrc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_action == ACT_ADD) begin
                        o_cmd.wr_en = !i_sts.full;
                        n_state     = S_DONE;
                    end else if (i_sts.count_zero) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.last_rd) begin
                    n_state = S_DRAIN;
                end
            end
            // last rule's read data is compared here
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/ftrc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftrc_datapath: rule table, compare and best-match tracking
// Holds the rule memories, the fill count, the scan index, the running best
// match and the output register.
// ----------------------------------------------------------------------------
module ftrc_datapath #(
    parameter int MAX_RULES = ftrc_pkg::DEF_MAX_RULES,
    parameter int RANK_BITS = ftrc_pkg::DEF_RANK_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ftrc_pkg::t_dp_cmd  i_cmd,
    input  ftrc_pkg::t_in_word i_in_word,
    input  logic               i_out_ready,
    output ftrc_pkg::t_dp_sts  o_sts,
    output logic               o_out_valid,
    output ftrc_pkg::t_out_word o_out_word
);
    import ftrc_pkg::*;

    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W = $clog2(MAX_RULES + 1);

    t_rule_key            mem_key  [MAX_RULES];
    logic [RANK_BITS-1:0] mem_rank [MAX_RULES];

    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     w_wr_addr;
    t_flow_key            r_key;
    logic                 r_is_add;
    logic                 r_full;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best_id;
    logic [RANK_BITS-1:0] r_best_rank;

    t_rule_key            r_rd_key;
    logic [RANK_BITS-1:0] r_rd_rank;
    logic                 r_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_id;

    logic                 r_out_valid;
    t_out_word            r_out_word;

    logic                 w_full;
    logic [RANK_BITS-1:0] w_in_rank;
    t_rule_key            w_new_rule;
    logic                 w_hit;
    logic [1:0]           w_status;
    logic [31:0]          w_id_wide;
    logic [31:0]          w_rank_wide;

    assign w_full    = (r_count >= CNT_W'(MAX_RULES));
    assign w_wr_addr = r_count[IDX_W-1:0];
    assign w_in_rank = RANK_BITS'(i_in_word.rule_rank);

    always_comb begin
        w_new_rule.ip_version    = i_in_word.ip_version;
        w_new_rule.protocol      = i_in_word.protocol;
        w_new_rule.l4_src        = i_in_word.l4_src;
        w_new_rule.l4_dst        = i_in_word.l4_dst;
        w_new_rule.src_addr      = i_in_word.src_addr;
        w_new_rule.src_addr_mask = i_in_word.src_addr_mask;
        w_new_rule.dst_addr      = i_in_word.dst_addr;
        w_new_rule.dst_addr_mask = i_in_word.dst_addr_mask;
        // wildcard address in an IPv4 rule is stored as zero
        if (i_in_word.ip_version == IPV4_VERSION && i_in_word.src_addr_mask == '0) begin
            w_new_rule.src_addr = '0;
        end
        if (i_in_word.ip_version == IPV4_VERSION && i_in_word.dst_addr_mask == '0) begin
            w_new_rule.dst_addr = '0;
        end
    end

    // rule memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem_key[w_wr_addr]  <= w_new_rule;
            mem_rank[w_wr_addr] <= w_in_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_key  <= mem_key[r_idx];
            r_rd_rank <= mem_rank[r_idx];
        end
    end

    always_comb begin
        w_hit = 1'b1;
        if (r_rd_key.ip_version != '0 && r_rd_key.ip_version != r_key.ip_version) begin
            w_hit = 1'b0;
        end
        if (r_rd_key.protocol != '0 && r_rd_key.protocol != r_key.protocol) begin
            w_hit = 1'b0;
        end
        if (r_rd_key.l4_src != '0 && r_rd_key.l4_src != r_key.l4_src) begin
            w_hit = 1'b0;
        end
        if (r_rd_key.l4_dst != '0 && r_rd_key.l4_dst != r_key.l4_dst) begin
            w_hit = 1'b0;
        end
        if (r_key.ip_version == IPV4_VERSION) begin
            if ((r_key.src_addr & r_rd_key.src_addr_mask)
                    != (r_rd_key.src_addr & r_rd_key.src_addr_mask)) begin
                w_hit = 1'b0;
            end
            if ((r_key.dst_addr & r_rd_key.dst_addr_mask)
                    != (r_rd_key.dst_addr & r_rd_key.dst_addr_mask)) begin
                w_hit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.rd_en;
            if (i_cmd.wr_en) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.capture) begin
                r_idx <= '0;
            end else if (i_cmd.rd_en) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // payload side of the scan; strict compare keeps the lower id on ties
    always_ff @(posedge i_clk) begin
        r_cmp_id <= r_idx;
        if (i_cmd.capture) begin
            r_key.ip_version <= i_in_word.ip_version;
            r_key.protocol   <= i_in_word.protocol;
            r_key.l4_src     <= i_in_word.l4_src;
            r_key.l4_dst     <= i_in_word.l4_dst;
            r_key.src_addr   <= i_in_word.src_addr;
            r_key.dst_addr   <= i_in_word.dst_addr;
            r_is_add         <= (i_in_word.action == ACT_ADD);
            r_full           <= w_full;
            r_found          <= 1'b0;
            if (i_in_word.action == ACT_ADD && !w_full) begin
                r_best_id   <= w_wr_addr;
                r_best_rank <= w_in_rank;
            end else begin
                r_best_id   <= '0;
                r_best_rank <= '0;
            end
        end else if (r_cmp_vld && w_hit && (!r_found || r_rd_rank < r_best_rank)) begin
            r_found     <= 1'b1;
            r_best_id   <= r_cmp_id;
            r_best_rank <= r_rd_rank;
        end
    end

    always_comb begin
        if (r_is_add) begin
            w_status = r_full ? ST_FULL : ST_ADDED;
        end else begin
            w_status = r_found ? ST_MATCH : ST_MISS;
        end
    end

    assign w_id_wide   = 32'(r_best_id);
    assign w_rank_wide = 32'(r_best_rank);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_word.status       <= w_status;
            r_out_word.matched_id   <= w_id_wide[ID_W-1:0];
            r_out_word.matched_rank <= w_rank_wide[RANK_W-1:0];
        end
    end

    assign o_sts.full       = w_full;
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.last_rd    = (CNT_W'(r_idx) == r_count - CNT_W'(1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

FILE: hdl/five_tuple_rule_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_tuple_rule_classifier_top: priority rule classifier on a flow 5-tuple
//
//   channel | valid       | ready       | word
//   --------+-------------+-------------+-------------
//   input   | i_in_valid  | o_in_ready  | i_in_word
//   output  | o_out_valid | i_out_ready | o_out_word
//
// An add goes from acceptance straight to the result stage; a lookup scans
// one rule per cycle through the single read port of the rule memory, then
// drains the last read. A lookup on an empty table skips the scan.
// Reset (i_rst_n low, synchronous) empties the table at once; the rule memory
// is not cleared, entries at or above the fill count are never read.
// A stalled result holds in the output register while the next word is
// accepted; the block waits for a free output register only at the end.
// ----------------------------------------------------------------------------
module five_tuple_rule_classifier_top #(
    parameter int MAX_RULES = ftrc_pkg::DEF_MAX_RULES,
    parameter int RANK_BITS = ftrc_pkg::DEF_RANK_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ftrc_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ftrc_pkg::t_out_word o_out_word
);
    import ftrc_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    ftrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_word.action),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    ftrc_datapath #(
        .MAX_RULES (MAX_RULES),
        .RANK_BITS (RANK_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

FILE: hdl/ftrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftrc_checker: port-level checks of the classifier
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module ftrc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input ftrc_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ftrc_pkg::t_out_word o_out_word
);
    import ftrc_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // one word at a time: ready drops right after an acceptance
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready stayed high after acceptance");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == ST_MISS |->
            o_out_word.matched_id == '0 && o_out_word.matched_rank == '0)
        else $error("miss result carries an id or rank");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == ST_FULL |->
            o_out_word.matched_id == '0 && o_out_word.matched_rank == '0)
        else $error("table-full result carries an id or rank");

    // no result appears in the cycle right after an acceptance
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result appeared one cycle after acceptance");

endmodule

bind five_tuple_rule_classifier_top ftrc_checker u_ftrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
